[rtl/agm_pkg.sv]
// Shared constants and types for the accelerometer sample to g magnitude block.
`default_nettype none
package agm_pkg;

    localparam int ADC_BITS  = 12;
    localparam int FRAC_BITS = 12;
    localparam int ACC_W     = 16;
    localparam int OFF_W     = 13;
    localparam int MAG_W     = 16;

    localparam int FULL_SCALE = (1 << ADC_BITS) - 1;

    // Scale 165 * 2^FRAC_BITS / (34 * FULL_SCALE), reduced by 30: 22528 / 4641.
    // Round to nearest: q = floor((mag * 2 * 22528 + 4641) / (2 * 4641)).
    localparam int SCALE_NUM2 = 45056;
    localparam int SCALE_DIV  = 9282;
    localparam int SCALE_HALF = 4641;
    localparam int NUM_W      = 28;
    localparam int Q_W        = 15;

    // Reciprocal of SCALE_DIV; exact floor for any NUM_W-bit numerator.
    localparam int RECIP_SHIFT = 42;
    localparam int RECIP_W     = 29;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W = NUM_W + RECIP_W;

    localparam int SUM_W  = 32;
    localparam int SQ_W   = 31;
    localparam int REM_W  = MAG_W + 1;
    localparam int ROOT_W = MAG_W;
    localparam int CELLS  = SUM_W / 2;

    typedef enum logic [2:0] {
        CFG_POS_X = 3'd0,
        CFG_POS_Y = 3'd1,
        CFG_POS_Z = 3'd2,
        CFG_NEG_X = 3'd3,
        CFG_NEG_Y = 3'd4,
        CFG_NEG_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [ADC_BITS-1:0] code_x;
        logic [ADC_BITS-1:0] code_y;
        logic [ADC_BITS-1:0] code_z;
    } t_sample;

    typedef struct packed {
        logic signed [ACC_W-1:0] accel_x;
        logic signed [ACC_W-1:0] accel_y;
        logic signed [ACC_W-1:0] accel_z;
        logic        [MAG_W-1:0] magnitude;
    } t_result;

    typedef logic [2:0][ACC_W-1:0] t_axes;

    typedef struct packed {
        logic              valid;
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        t_axes             axes;
    } t_sqrt_stage;

endpackage
`default_nettype wire

[rtl/agm_axis.sv]
// One axis: bias removal, scaling to 1/4096 g and side-dependent calibration offset.
`default_nettype none
module agm_axis (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic [agm_pkg::ADC_BITS-1:0]         i_code,
    input  wire logic signed [agm_pkg::OFF_W-1:0]     i_pos_off,
    input  wire logic signed [agm_pkg::OFF_W-1:0]     i_neg_off,
    output logic signed [agm_pkg::ACC_W-1:0]          o_accel
);

    localparam int CW = agm_pkg::ADC_BITS + 1;

    logic [CW-1:0]                    w_c2;
    logic                             w_neg;
    logic [CW-1:0]                    w_mag;
    logic [agm_pkg::NUM_W-1:0]        w_num;
    logic [agm_pkg::PROD_W-1:0]       w_prod;
    logic signed [agm_pkg::ACC_W:0]   w_val;
    logic signed [agm_pkg::ACC_W:0]   w_off;
    logic signed [agm_pkg::ACC_W:0]   w_sum;

    logic [agm_pkg::NUM_W-1:0]        r_num;
    logic                             r_neg1;
    logic [agm_pkg::Q_W-1:0]          r_q;
    logic                             r_neg2;
    logic signed [agm_pkg::ACC_W-1:0] r_accel;
    logic signed [agm_pkg::ACC_W-1:0] n_accel;

    // Negative exactly when 2*code < full scale, i.e. the code's top bit is clear.
    assign w_c2  = {i_code, 1'b0};
    assign w_neg = ~i_code[agm_pkg::ADC_BITS-1];
    assign w_mag = w_neg ? (CW'(agm_pkg::FULL_SCALE) - w_c2)
                         : (w_c2 - CW'(agm_pkg::FULL_SCALE));
    assign w_num = agm_pkg::NUM_W'(w_mag) * agm_pkg::NUM_W'(agm_pkg::SCALE_NUM2)
                 + agm_pkg::NUM_W'(agm_pkg::SCALE_HALF);

    assign w_prod = agm_pkg::PROD_W'(r_num) * agm_pkg::PROD_W'(agm_pkg::RECIP);

    always_comb begin
        w_val = $signed({2'b00, r_q});
        if (r_neg2) begin
            w_val = -w_val;
        end
        w_off = (agm_pkg::ACC_W+1)'(r_neg2 ? i_neg_off : i_pos_off);
        w_sum = w_val + w_off;
        if (w_sum > 17'sd32767) begin
            n_accel = 16'sh7FFF;
        end else if (w_sum < -17'sd32768) begin
            n_accel = 16'sh8000;
        end else begin
            n_accel = w_sum[agm_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= w_num;
            r_neg1  <= w_neg;
            r_q     <= w_prod[agm_pkg::PROD_W-1:agm_pkg::RECIP_SHIFT];
            r_neg2  <= r_neg1;
            r_accel <= n_accel;
        end
    end

    assign o_accel = r_accel;

endmodule
`default_nettype wire

[rtl/agm_sqrt_cell.sv]
// One square root cell: retires two radicand bits and produces one root bit.
`default_nettype none
module agm_sqrt_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire agm_pkg::t_sqrt_stage i_stage,
    output agm_pkg::t_sqrt_stage      o_stage
);

    localparam int CUR_W = agm_pkg::REM_W + 2;

    logic [CUR_W-1:0]      w_cur;
    logic [CUR_W-1:0]      w_trial;
    logic                  w_fit;
    agm_pkg::t_sqrt_stage  n_stage;
    agm_pkg::t_sqrt_stage  r_stage;

    assign w_cur   = {i_stage.rem, i_stage.rad[agm_pkg::SUM_W-1 -: 2]};
    assign w_trial = {1'b0, i_stage.root, 2'b01};
    assign w_fit   = w_cur >= w_trial;

    always_comb begin
        n_stage       = i_stage;
        n_stage.rad   = {i_stage.rad[agm_pkg::SUM_W-3:0], 2'b00};
        n_stage.root  = {i_stage.root[agm_pkg::ROOT_W-2:0], w_fit};
        n_stage.rem   = w_fit ? agm_pkg::REM_W'(w_cur - w_trial)
                              : w_cur[agm_pkg::REM_W-1:0];
    end

    // Valid bit is control; the rest is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.rad  <= n_stage.rad;
            r_stage.rem  <= n_stage.rem;
            r_stage.root <= n_stage.root;
            r_stage.axes <= n_stage.axes;
        end
    end

    assign o_stage = r_stage;

endmodule
`default_nettype wire

[rtl/accel_sample_to_g_magnitude.sv]
// Top level: three-axis code to g conversion with calibrated vector magnitude.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one sample of three
// unsigned converter codes per transaction. Output channel (o_out_valid /
// i_out_ready / o_out_data) returns one result per sample, in order: three
// signed accelerations in 1/4096 g and the rounded, saturated magnitude.
// Throughput: one transaction per cycle while the receiver does not stall.
// A sample passes through the per-axis scaling registers (two constant
// multiplies and the offset add), one register for the squares, one for their
// sum, the chain of square root cells (one root bit each) and one output
// register holding the rounded magnitude.
// The whole pipeline advances together; when the output holds a result that
// is not taken, every stage holds and o_in_ready drops, so nothing is lost.
// A bubble at the output lets the pipeline move even if i_out_ready is low.
// Reset (i_rst_n low, synchronous) clears all valid bits and zeroes all six
// calibration offsets. Offsets are written through i_cfg_we / i_cfg_idx /
// i_cfg_data, by the user only while idle (unchecked); indexes above 5 drop.
`default_nettype none
module accel_sample_to_g_magnitude (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire agm_pkg::t_sample                 i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output agm_pkg::t_result                      o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [2:0]                       i_cfg_idx,
    input  wire logic [agm_pkg::OFF_W-1:0]        i_cfg_data
);

    localparam int ACC_W = agm_pkg::ACC_W;

    // Calibration offsets, indexed by axis (0 = x, 1 = y, 2 = z).
    logic signed [agm_pkg::OFF_W-1:0] r_pos_off [3];
    logic signed [agm_pkg::OFF_W-1:0] r_neg_off [3];

    logic                               w_adv;
    logic [4:0]                         r_vld;
    logic [2:0][agm_pkg::ADC_BITS-1:0]  w_codes;
    logic signed [ACC_W-1:0]            w_acc [3];
    logic [agm_pkg::SQ_W-1:0]           r_sq  [3];
    logic signed [2*ACC_W-1:0]          w_sq_full [3];
    agm_pkg::t_axes                     r_axes4;
    agm_pkg::t_axes                     r_axes5;
    logic [agm_pkg::SUM_W-1:0]          r_sum;
    agm_pkg::t_sqrt_stage               w_chain [agm_pkg::CELLS+1];

    logic [agm_pkg::ROOT_W:0]           w_round;
    logic [agm_pkg::MAG_W-1:0]          w_mag;
    logic                               r_out_valid;
    agm_pkg::t_result                   r_out_data;

    // Advance the whole pipeline unless a finished result is waiting.
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos_off[i] <= '0;
                r_neg_off[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (agm_pkg::t_cfg_idx'(i_cfg_idx))
                agm_pkg::CFG_POS_X: r_pos_off[0] <= $signed(i_cfg_data);
                agm_pkg::CFG_POS_Y: r_pos_off[1] <= $signed(i_cfg_data);
                agm_pkg::CFG_POS_Z: r_pos_off[2] <= $signed(i_cfg_data);
                agm_pkg::CFG_NEG_X: r_neg_off[0] <= $signed(i_cfg_data);
                agm_pkg::CFG_NEG_Y: r_neg_off[1] <= $signed(i_cfg_data);
                agm_pkg::CFG_NEG_Z: r_neg_off[2] <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Valid tracking for scaling (3 stages), squares and sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[3:0], i_in_valid};
        end
    end

    assign w_codes[0] = i_in_data.code_x;
    assign w_codes[1] = i_in_data.code_y;
    assign w_codes[2] = i_in_data.code_z;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        agm_axis u_axis (
            .i_clk     (i_clk),
            .i_en      (w_adv),
            .i_code    (w_codes[g]),
            .i_pos_off (r_pos_off[g]),
            .i_neg_off (r_neg_off[g]),
            .o_accel   (w_acc[g])
        );

        // |accel| <= 32768, so the square fits in 31 bits.
        assign w_sq_full[g] = (2*ACC_W)'(w_acc[g]) * (2*ACC_W)'(w_acc[g]);
    end

    // Squares, then their sum; carry the accelerations alongside.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i]    <= w_sq_full[i][agm_pkg::SQ_W-1:0];
                r_axes4[i] <= w_acc[i];
            end
            r_sum   <= agm_pkg::SUM_W'(r_sq[0]) + agm_pkg::SUM_W'(r_sq[1])
                     + agm_pkg::SUM_W'(r_sq[2]);
            r_axes5 <= r_axes4;
        end
    end

    // Square root chain: each cell retires two radicand bits.
    always_comb begin
        w_chain[0].valid = r_vld[4];
        w_chain[0].rad   = r_sum;
        w_chain[0].rem   = '0;
        w_chain[0].root  = '0;
        w_chain[0].axes  = r_axes5;
    end

    for (genvar c = 0; c < agm_pkg::CELLS; c++) begin : g_cell
        agm_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_stage (w_chain[c]),
            .o_stage (w_chain[c+1])
        );
    end

    // Round to nearest: bump when the remainder exceeds the root, then saturate.
    always_comb begin
        w_round = {1'b0, w_chain[agm_pkg::CELLS].root};
        if (w_chain[agm_pkg::CELLS].rem > agm_pkg::REM_W'(w_chain[agm_pkg::CELLS].root)) begin
            w_round = w_round + (agm_pkg::ROOT_W+1)'(1);
        end
        w_mag = w_round[agm_pkg::ROOT_W] ? '1 : w_round[agm_pkg::MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_chain[agm_pkg::CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data.accel_x   <= $signed(w_chain[agm_pkg::CELLS].axes[0]);
            r_out_data.accel_y   <= $signed(w_chain[agm_pkg::CELLS].axes[1]);
            r_out_data.accel_z   <= $signed(w_chain[agm_pkg::CELLS].axes[2]);
            r_out_data.magnitude <= w_mag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A stalled result must hold the input side off.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // The vector length is never shorter than its x component.
    a_mag_covers_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out_data.magnitude} >=
            (o_out_data.accel_x[ACC_W-1] ? 17'(-$signed({o_out_data.accel_x[ACC_W-1],
                                                           o_out_data.accel_x}))
                                          : 17'(o_out_data.accel_x))))
        else $error("magnitude below |accel_x|");

    // Zero magnitude only for a zero vector.
    a_zero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.magnitude == '0) |->
            (o_out_data.accel_x == '0 && o_out_data.accel_y == '0 &&
             o_out_data.accel_z == '0))
        else $error("zero magnitude for nonzero vector");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

[tb/accel_sample_to_g_magnitude_tb.sv]
// Self-checking testbench for accel_sample_to_g_magnitude: predicted g vectors against the pipeline.
`timescale 1ns / 100ps

module accel_sample_to_g_magnitude_tb;
    import agm_pkg::*;

    // Code to g: (2*code - FS) * 3.3 / (2 * 0.34 * FS) g, i.e. a ratio of 165 / 34.
    localparam int SUPPLY_NUM = 165;
    localparam int SENS_NUM = 34;
    localparam int ACC_MAX = 32767;
    localparam int ACC_MIN = -32768;
    localparam longint MAG_MAX = 65535;
    localparam int OFF_MAX = 4095;
    localparam int OFF_MIN = -4096;
    localparam int NUM_OFFSETS = 6;
    // Spare register indexes; the block drops writes to them.
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int PACE_RUN = 50;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        PACE_FULL,
        PACE_RANDOM,
        PACE_LIGHT
    } pace_t;

    typedef int offset_set_t[NUM_OFFSETS];

    // Holds the calibration offsets, predicts every accepted sample and
    // matches results in order against the predictions.
    class g_vector_scoreboard;
        int offsets[NUM_OFFSETS];
        t_result pending_vectors[$];
        int mismatches;

        function new();
            foreach (offsets[i]) offsets[i] = 0;
            mismatches = 0;
        endfunction

        function void set_offset(logic [2:0] idx, logic [OFF_W-1:0] value);
            if (idx < NUM_OFFSETS) offsets[idx] = $signed(value);
        endfunction

        function int pending();
            return pending_vectors.size();
        endfunction

        // Remove the zero-g bias, scale to 1/4096 g rounding half away from zero,
        // add the offset of the side the exact value falls on, and clamp.
        function int axis_to_g(logic [ADC_BITS-1:0] code, int pos_off, int neg_off);
            longint twice;
            longint span;
            longint q;
            longint g;
            bit below;
            twice = 2 * longint'(code);
            below = twice < FULL_SCALE;
            span = below ? FULL_SCALE - twice : twice - FULL_SCALE;
            q = (2 * span * SUPPLY_NUM * (longint'(1) << FRAC_BITS) + SENS_NUM * FULL_SCALE)
                / (2 * SENS_NUM * FULL_SCALE);
            g = below ? neg_off - q : q + pos_off;
            if (g > ACC_MAX) g = ACC_MAX;
            else if (g < ACC_MIN) g = ACC_MIN;
            return int'(g);
        endfunction

        // Square root rounded to nearest, clamped to the magnitude range.
        function longint rounded_root(longint sum);
            longint root;
            longint trial;
            int b;
            root = 0;
            for (b = 17; b >= 0; b--) begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= sum) root = trial;
            end
            if (sum > root * root + root) root++;
            if (root > MAG_MAX) root = MAG_MAX;
            return root;
        endfunction

        function void note_sample(t_sample s);
            t_result r;
            int ax;
            int ay;
            int az;
            longint mag;
            ax = axis_to_g(s.code_x, offsets[CFG_POS_X], offsets[CFG_NEG_X]);
            ay = axis_to_g(s.code_y, offsets[CFG_POS_Y], offsets[CFG_NEG_Y]);
            az = axis_to_g(s.code_z, offsets[CFG_POS_Z], offsets[CFG_NEG_Z]);
            mag = rounded_root(longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az);
            r.accel_x = ax[ACC_W-1:0];
            r.accel_y = ay[ACC_W-1:0];
            r.accel_z = az[ACC_W-1:0];
            r.magnitude = mag[MAG_W-1:0];
            pending_vectors.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_vectors.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result with no sample pending: x=%0d y=%0d z=%0d mag=%0d",
                             got.accel_x, got.accel_y, got.accel_z, got.magnitude);
                return;
            end
            want = pending_vectors.pop_front();
            if (got.accel_x !== want.accel_x || got.accel_y !== want.accel_y ||
                got.accel_z !== want.accel_z || got.magnitude !== want.magnitude) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: expected x=%0d y=%0d z=%0d mag=%0d,",
                              " got x=%0d y=%0d z=%0d mag=%0d"},
                             want.accel_x, want.accel_y, want.accel_z, want.magnitude,
                             got.accel_x, got.accel_y, got.accel_z, got.magnitude);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_sample in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_result out_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_idx = 3'(CFG_POS_X);
    logic [OFF_W-1:0] cfg_data = '0;

    g_vector_scoreboard sb;
    pace_t tx_pace = PACE_FULL;
    pace_t rx_pace = PACE_FULL;
    int rx_hold = 0;
    int rx_taken = 0;
    int cycles = 0;

    accel_sample_to_g_magnitude dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("accel_sample_to_g_magnitude regression: fail");
            $finish;
        end
    end

    // Draw the idle cycles before the next transaction for one side.
    function automatic int draw_wait(pace_t pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_LIGHT:  return $urandom_range(0, 2);
            default:     return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic t_sample make_sample(int x, int y, int z);
        t_sample s;
        s.code_x = x[ADC_BITS-1:0];
        s.code_y = y[ADC_BITS-1:0];
        s.code_z = z[ADC_BITS-1:0];
        return s;
    endfunction

    // Mix full-range codes with codes around the zero-g point, where the sign
    // decision and the rounding are tight, and with the rails.
    function automatic int random_code();
        int code;
        case ($urandom_range(0, 3))
            0, 1: code = $urandom_range(0, FULL_SCALE);
            2:    code = $urandom_range(FULL_SCALE / 2 - 8, FULL_SCALE / 2 + 9);
            default: begin
                case ($urandom_range(0, 5))
                    0:       code = 0;
                    1:       code = 1;
                    2:       code = FULL_SCALE / 2;
                    3:       code = FULL_SCALE / 2 + 1;
                    4:       code = FULL_SCALE - 1;
                    default: code = FULL_SCALE;
                endcase
            end
        endcase
        return code;
    endfunction

    // Drive one sample after its idle gap and hold it until the transaction.
    // Keep valid high across back-to-back samples.
    task automatic send_sample(t_sample s);
        int gap;
        gap = draw_wait(tx_pace);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(s);
    endtask

    // Write all six offsets, then poke the spare indexes with junk.
    task automatic load_offsets(offset_set_t values);
        int i;
        logic [OFF_W-1:0] junk;
        for (i = 0; i < NUM_OFFSETS; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= 3'(t_cfg_idx'(i));
            cfg_data <= values[i][OFF_W-1:0];
            @(posedge clk);
            sb.set_offset(3'(t_cfg_idx'(i)), values[i][OFF_W-1:0]);
        end
        junk = OFF_W'($urandom);
        cfg_idx <= CFG_SPARE_6;
        cfg_data <= junk;
        @(posedge clk);
        sb.set_offset(CFG_SPARE_6, junk);
        junk = OFF_W'($urandom);
        cfg_idx <= CFG_SPARE_7;
        cfg_data <= junk;
        @(posedge clk);
        sb.set_offset(CFG_SPARE_7, junk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: check every result transaction, then stall for a drawn number
    // of cycles before taking the next one.
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_hold = 0;
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                sb.check_result(out_data);
                rx_taken++;
                if (rx_taken % PACE_RUN == 0) rx_pace = pace_t'($urandom_range(0, 2));
                rx_hold = draw_wait(rx_pace);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            out_ready <= (rx_hold == 0);
        end
    end

    initial begin
        offset_set_t plan;
        int phase;
        int n;
        int i;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rails, the codes either side of zero g, and mixed signs,
        // all with the reset offsets of zero.
        send_sample(make_sample(0, 0, 0));
        send_sample(make_sample(FULL_SCALE, FULL_SCALE, FULL_SCALE));
        send_sample(make_sample(FULL_SCALE / 2, FULL_SCALE / 2, FULL_SCALE / 2));
        send_sample(make_sample(FULL_SCALE / 2 + 1, FULL_SCALE / 2 + 1, FULL_SCALE / 2 + 1));
        send_sample(make_sample(FULL_SCALE / 2, FULL_SCALE / 2 + 1, 0));
        send_sample(make_sample(FULL_SCALE, 0, FULL_SCALE / 2 + 1));
        send_sample(make_sample(1, FULL_SCALE - 1, FULL_SCALE / 2));
        send_sample(make_sample(0, FULL_SCALE, FULL_SCALE));
        send_sample(make_sample(FULL_SCALE - 1, 1, FULL_SCALE / 2 - 1));
        send_sample(make_sample(FULL_SCALE / 2 + 2, FULL_SCALE / 2 - 1, 1));
        send_sample(make_sample(2730, 1365, 3000));
        send_sample(make_sample(FULL_SCALE, FULL_SCALE, 0));

        for (phase = 0; phase < PHASES; phase++) begin
            // Pause the sender until the pipeline is empty, then reprogram.
            in_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clk);
            for (i = 0; i < NUM_OFFSETS; i++) begin
                case (phase)
                    0:       plan[i] = OFF_MAX;
                    1:       plan[i] = OFF_MIN;
                    2:       plan[i] = (i < 3) ? OFF_MAX : OFF_MIN;
                    3:       plan[i] = (i < 3) ? OFF_MIN : OFF_MAX;
                    4:       plan[i] = 0;
                    default: plan[i] = int'($urandom_range(0, OFF_MAX - OFF_MIN)) + OFF_MIN;
                endcase
            end
            load_offsets(plan);

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % PACE_RUN == 0) tx_pace = pace_t'($urandom_range(0, 2));
                send_sample(make_sample(random_code(), random_code(), random_code()));
            end
        end

        // Drain: wait for every result, then watch for strays.
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("accel_sample_to_g_magnitude regression: pass");
        end else begin
            $display("accel_sample_to_g_magnitude regression: fail");
        end
        $finish;
    end

endmodule
